// ----- src/virtual_fat16_sector_reader_defines.svh -----
// Assertion macros for the virtual FAT16 sector reader.
// No dependencies; included by the top level, which must declare i_clk and i_rst_n.
`ifndef VIRTUAL_FAT16_SECTOR_READER_DEFINES_SVH
`define VIRTUAL_FAT16_SECTOR_READER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define VFAT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define VFAT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/vfat_pkg.sv -----
// Shared types, disk geometry and text content for the virtual FAT16 sector reader.
// No dependencies; imported by vfat_rom and virtual_fat16_sector_reader.
package vfat_pkg;

    // Geometry
    localparam int SECTOR_BYTES        = 512;
    localparam int SECTORS_PER_CLUSTER = 8;
    localparam int FAT_SECTORS         = 16;
    localparam int ROOT_ENTRIES        = 128;

    localparam int RESERVED_SECTORS = 1;
    localparam int FAT_COPIES       = 2;
    localparam int ROOT_SECTORS     = (ROOT_ENTRIES * 32 + SECTOR_BYTES - 1) / SECTOR_BYTES;
    localparam int FAT1_LBA         = RESERVED_SECTORS;
    localparam int FAT2_LBA         = FAT1_LBA + FAT_SECTORS;
    localparam int ROOT_LBA         = FAT1_LBA + FAT_COPIES * FAT_SECTORS;
    localparam int DATA_LBA         = ROOT_LBA + ROOT_SECTORS;
    localparam int PAGE_LBA         = DATA_LBA + SECTORS_PER_CLUSTER;   // cluster 3

    localparam logic [15:0] BPS_W  = 16'(SECTOR_BYTES);
    localparam logic [7:0]  SPC_W  = 8'(SECTORS_PER_CLUSTER);
    localparam logic [15:0] RSV_W  = 16'(RESERVED_SECTORS);
    localparam logic [7:0]  NFAT_W = 8'(FAT_COPIES);
    localparam logic [15:0] RE_W   = 16'(ROOT_ENTRIES);
    localparam logic [15:0] FATS_W = 16'(FAT_SECTORS);

    localparam logic [7:0] MEDIA_BYTE = 8'hF8;

    // Register reset values
    localparam logic [15:0] TOTAL_SECTORS_RST = 16'd8192;
    localparam logic [63:0] LABEL_HEAD_RST    = 64'h2020_2020_2020_2020;
    localparam logic [23:0] LABEL_TAIL_RST    = 24'h20_2020;

    localparam int CFG_DATA_W = 64;

    typedef enum logic [1:0] {
        CFG_TOTAL_SECTORS = 2'd0,
        CFG_LABEL_HEAD    = 2'd1,
        CFG_LABEL_TAIL    = 2'd2
    } t_cfg_index;

    // File contents, first character in the most significant byte
    localparam logic [15:0] CRLF = 16'h0D0A;

    localparam INFO_TEXT = {
        "UF2 Bootloader", CRLF,
        "Model: MX25UW25645GXDI00_STM3", "2H7S3Z8T", CRLF,
        "Board-ID: STM3", "2H7S3Z8T", CRLF
    };

    localparam PAGE_TEXT = {
        "<!doctype html><html><head><meta charset=\"utf-8\">",
        "<title>UF2BOOT</title></head><body>",
        "<h3>UF2BOOT</h3>",
        "<p>Drag and drop a UF2 file to update the application.</p>",
        "</body></html>", CRLF
    };

    localparam int INFO_LEN = $bits(INFO_TEXT) / 8;
    localparam int PAGE_LEN = $bits(PAGE_TEXT) / 8;

    localparam logic [9:0]  INFO_LEN_W  = 10'(INFO_LEN);
    localparam logic [9:0]  PAGE_LEN_W  = 10'(PAGE_LEN);
    localparam logic [31:0] INFO_SIZE_W = 32'(INFO_LEN);
    localparam logic [31:0] PAGE_SIZE_W = 32'(PAGE_LEN);

    // Transactions
    typedef struct packed {
        logic [31:0] sector_address;
        logic [8:0]  byte_index;
        logic        last_in_read;
    } t_in_item;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       out_of_range;
        logic       last_byte;
    } t_out_item;

    // File ROM address: page selects the HTML file, else the info file
    typedef struct packed {
        logic       page;
        logic [7:0] idx;
    } t_rom_addr;

endpackage

// ----- src/vfat_rom.sv -----
// Synchronous ROM holding the two text files of the data area.
// Depends on vfat_pkg for the file texts and the address type.
module vfat_rom import vfat_pkg::*; (
    input  logic      i_clk,
    input  logic      i_en,
    input  t_rom_addr i_addr,
    output logic [7:0] o_data
);

    logic [7:0] r_data;

    function automatic logic [7:0] rom_byte(t_rom_addr a);
        logic [9:0] idx;
        logic [7:0] b;
        idx = {2'b00, a.idx};
        b   = 8'h00;
        if (a.page) begin
            if (idx < PAGE_LEN_W) begin
                b = PAGE_TEXT[8 * (PAGE_LEN - 1 - int'(idx)) +: 8];
            end
        end else begin
            if (idx < INFO_LEN_W) begin
                b = INFO_TEXT[8 * (INFO_LEN - 1 - int'(idx)) +: 8];
            end
        end
        return b;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= rom_byte(i_addr);
        end
    end

    assign o_data = r_data;

endmodule

// ----- src/virtual_fat16_sector_reader.sv -----
// Channel  | Signals                                   | Direction
// ---------+-------------------------------------------+----------
// in       | i_in_valid / o_in_ready / i_in_item       | to block
// out      | o_out_valid / i_out_ready / o_out_item    | from block
// cfg      | i_cfg_we / i_cfg_index / i_cfg_wdata      | to block
//
// Two-stage pipeline: decode plus file ROM read, then byte select into the
// output register. One transaction per cycle while the output is not stalled.
// Synchronous active-low reset clears both valid bits and loads the register
// defaults. A stall at the output holds both stages; the input takes a
// transaction whenever the decode stage is empty or moves on.
// Depends on vfat_pkg, vfat_rom and the assertion macro header.
`include "virtual_fat16_sector_reader_defines.svh"

module virtual_fat16_sector_reader import vfat_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    typedef enum logic [4:0] {
        REG_ZERO = 5'b00001,
        REG_BOOT = 5'b00010,
        REG_FAT  = 5'b00100,
        REG_ROOT = 5'b01000,
        REG_FILE = 5'b10000
    } t_region;

    typedef struct packed {
        t_region    region;
        logic [8:0] byte_index;
        logic       oor;
        logic       last;
    } t_s1;

    localparam logic [63:0] OEM_NAME = "MSDOS5.0";
    localparam logic [63:0] FS_TYPE  = "FAT16   ";
    localparam logic [87:0] INFO_NAME = "INFO_UF2TXT";
    localparam logic [87:0] PAGE_NAME = "INDEX   HTM";

    logic [15:0] r_total_sectors;
    logic [63:0] r_label_head;
    logic [23:0] r_label_tail;

    logic       r_s1_valid;
    t_s1        r_s1;
    t_s1        n_s1;
    logic       r_out_valid;
    t_out_item  r_out;
    t_out_item  n_out;

    logic       s1_free;
    logic       out_load;
    logic       in_fire;
    t_rom_addr  rom_addr;
    logic [7:0] rom_data;

    // ---------------- byte generators ----------------
    function automatic logic [7:0] label_char(logic [3:0] k, logic [63:0] head,
                                              logic [23:0] tail);
        logic [7:0] b;
        if (k < 4'd8) begin
            b = head[8 * k[2:0] +: 8];
        end else if (k[1:0] == 2'd3) begin
            b = 8'h00;
        end else begin
            b = tail[8 * k[1:0] +: 8];
        end
        return b;
    endfunction

    function automatic logic [7:0] boot_byte(logic [8:0] i, logic [15:0] total,
                                             logic [63:0] head, logic [23:0] tail);
        logic [8:0] d_oem;
        logic [8:0] d_lbl;
        logic [8:0] d_fs;
        logic [7:0] b;
        d_oem = i - 9'h003;
        d_lbl = i - 9'h02B;
        d_fs  = i - 9'h036;
        case (i) inside
            9'h000: b = 8'hEB;
            9'h001: b = 8'h3C;
            9'h002: b = 8'h90;
            [9'h003:9'h00A]: b = OEM_NAME[8 * (3'd7 - d_oem[2:0]) +: 8];
            9'h00B: b = BPS_W[7:0];
            9'h00C: b = BPS_W[15:8];
            9'h00D: b = SPC_W;
            9'h00E: b = RSV_W[7:0];
            9'h00F: b = RSV_W[15:8];
            9'h010: b = NFAT_W;
            9'h011: b = RE_W[7:0];
            9'h012: b = RE_W[15:8];
            9'h013: b = total[7:0];
            9'h014: b = total[15:8];
            9'h015: b = MEDIA_BYTE;
            9'h016: b = FATS_W[7:0];
            9'h017: b = FATS_W[15:8];
            9'h018: b = 8'h3F;
            9'h01A: b = 8'hFF;
            9'h024: b = 8'h80;
            9'h026: b = 8'h29;
            9'h027: b = 8'h78;
            9'h028: b = 8'h56;
            9'h029: b = 8'h34;
            9'h02A: b = 8'h12;
            [9'h02B:9'h035]: b = label_char(d_lbl[3:0], head, tail);
            [9'h036:9'h03D]: b = FS_TYPE[8 * (3'd7 - d_fs[2:0]) +: 8];
            9'h1FE: b = 8'h55;
            9'h1FF: b = 8'hAA;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] file_entry(logic [4:0] k, logic [87:0] name,
                                              logic [15:0] cluster, logic [31:0] size);
        logic [7:0] b;
        b = 8'h00;
        if (k < 5'd11) begin
            b = name[8 * (4'd10 - k[3:0]) +: 8];
        end else if (k == 5'd11) begin
            b = 8'h20;
        end else if (k == 5'd26 || k == 5'd27) begin
            b = cluster[8 * k[0] +: 8];
        end else if (k >= 5'd28) begin
            b = size[8 * k[1:0] +: 8];
        end
        return b;
    endfunction

    function automatic logic [7:0] root_byte(logic [8:0] i, logic [63:0] head,
                                             logic [23:0] tail);
        logic [4:0] k;
        logic [7:0] b;
        k = i[4:0];
        case (i[8:5])
            4'd0: begin
                if (k < 5'd11) begin
                    b = label_char(k[3:0], head, tail);
                end else begin
                    b = (k == 5'd11) ? 8'h08 : 8'h00;    // volume label attribute
                end
            end
            4'd1:    b = file_entry(k, INFO_NAME, 16'd2, INFO_SIZE_W);
            4'd2:    b = file_entry(k, PAGE_NAME, 16'd3, PAGE_SIZE_W);
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_sectors <= TOTAL_SECTORS_RST;
            r_label_head    <= LABEL_HEAD_RST;
            r_label_tail    <= LABEL_TAIL_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_TOTAL_SECTORS: r_total_sectors <= i_cfg_wdata[15:0];
                CFG_LABEL_HEAD:    r_label_head    <= i_cfg_wdata;
                CFG_LABEL_TAIL:    r_label_tail    <= i_cfg_wdata[23:0];
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    assign out_load   = !r_out_valid || i_out_ready;
    assign s1_free    = !r_s1_valid || out_load;
    assign in_fire    = i_in_valid && s1_free;
    assign o_in_ready = s1_free;

    // ---------------- stage 1: decode ----------------
    always_comb begin
        logic [31:0] lba;
        logic [9:0]  bi;
        lba = i_in_item.sector_address;
        bi  = {1'b0, i_in_item.byte_index};
        n_s1.byte_index = i_in_item.byte_index;
        n_s1.last       = i_in_item.last_in_read;
        n_s1.oor        = lba >= {16'h0000, r_total_sectors};
        n_s1.region     = REG_ZERO;
        if (!n_s1.oor) begin
            if (lba == 32'd0) begin
                n_s1.region = REG_BOOT;
            end else if (lba == 32'(FAT1_LBA) || lba == 32'(FAT2_LBA)) begin
                // only the first eight bytes of each copy carry entries
                n_s1.region = (bi < 10'd8) ? REG_FAT : REG_ZERO;
            end else if (lba == 32'(ROOT_LBA)) begin
                n_s1.region = REG_ROOT;
            end else if ((lba == 32'(DATA_LBA) && bi < INFO_LEN_W) ||
                         (lba == 32'(PAGE_LBA) && bi < PAGE_LEN_W)) begin
                n_s1.region = REG_FILE;
            end
        end
        rom_addr.page = (lba == 32'(PAGE_LBA));
        rom_addr.idx  = i_in_item.byte_index[7:0];
    end

    vfat_rom u_rom (
        .i_clk  (i_clk),
        .i_en   (in_fire),
        .i_addr (rom_addr),
        .o_data (rom_data)
    );

    // ---------------- stage 2: byte select ----------------
    always_comb begin
        n_out.out_of_range = r_s1.oor;
        n_out.last_byte    = r_s1.last;
        case (r_s1.region)
            REG_BOOT: n_out.data_byte = boot_byte(r_s1.byte_index, r_total_sectors,
                                                  r_label_head, r_label_tail);
            REG_FAT:  n_out.data_byte = (r_s1.byte_index == 9'd0) ? MEDIA_BYTE : 8'hFF;
            REG_ROOT: n_out.data_byte = root_byte(r_s1.byte_index, r_label_head,
                                                  r_label_tail);
            REG_FILE: n_out.data_byte = rom_data;
            default:  n_out.data_byte = 8'h00;
        endcase
    end

    // ---------------- pipeline registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= i_in_valid;
            end
            if (out_load) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1 <= n_s1;
        end
        if (out_load && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // ---------------- assertions ----------------
    `VFAT_ASSERT_NOW(a_region_onehot, r_s1_valid, $onehot(r_s1.region), "decode region not one-hot")
    `VFAT_ASSERT_NOW(a_oor_zero, o_out_valid && o_out_item.out_of_range, o_out_item.data_byte == 8'h00, "out of range transaction with nonzero data")
    `VFAT_ASSERT_NOW(a_full_stall, r_s1_valid && r_out_valid && !i_out_ready, !o_in_ready, "input ready while both stages are held")
    `VFAT_ASSERT_NEXT(a_fire_fills, in_fire, r_s1_valid, "accepted transaction lost in decode stage")

endmodule
